FILE: sv/sfvc_pkg.sv
`timescale 1ns / 1ps

package sfvc_pkg;

    // Taylor series: seven sine terms, eight cosine terms
    localparam int TERMS = 8;

    // Angles in Q30 radians
    localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
    localparam logic [31:0]        ONE_Q30     = 32'd1073741824;

    // Velocity full scale, Q1.14
    localparam logic [14:0] VEL_ONE = 15'd16384;

    // Spring gain after reset, Q8.8
    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Per-term divisors n*(n+1), reciprocals floor(2^K / d) and shifts K.
    // The reciprocal estimate is low by at most one; one correction fixes it.
    localparam logic [7:0] SIN_DIV [0:TERMS-1] = '{
        8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156, 8'd210, 8'd1};
    localparam logic [31:0] SIN_MUL [0:TERMS-1] = '{
        32'd2863311530, 32'd3435973836, 32'd3272356035, 32'd3817748707,
        32'd2498890063, 32'd3524075730, 32'd2617884828, 32'd0};
    localparam int SIN_SHIFT [0:TERMS-1] = '{34, 36, 37, 38, 38, 39, 39, 32};

    localparam logic [7:0] COS_DIV [0:TERMS-1] = '{
        8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182, 8'd240};
    localparam logic [31:0] COS_MUL [0:TERMS-1] = '{
        32'd2147483648, 32'd2863311530, 32'd2290649224, 32'd2454267026,
        32'd3054198966, 32'd4164816771, 32'd3020636340, 32'd2290649224};
    localparam int COS_SHIFT [0:TERMS-1] = '{32, 35, 36, 37, 38, 39, 39, 39};

    // Position difference and offset magnitudes
    typedef struct packed {
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic [31:0]        ox_mag;
        logic [31:0]        oy_mag;
    } t_geo;

    // Trig values and axis signs traveling beside the magnitude path
    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
        logic               sx_nz;
        logic               sx_neg;
        logic               sy_nz;
        logic               sy_neg;
        logic               sh;
    } t_side;

endpackage

FILE: sv/sfvc_trig.sv
`timescale 1ns / 1ps

// Heading to cosine and sine, Q30, one Taylor term per three stages
module sfvc_trig (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic signed [15:0]  i_heading,
    input  sfvc_pkg::t_geo      i_geo,
    output logic                o_valid,
    output logic signed [31:0]  o_cos,
    output logic signed [31:0]  o_sin,
    output sfvc_pkg::t_geo      o_geo
);

    typedef struct packed {
        logic [31:0]        ts;
        logic [31:0]        tc;
        logic signed [33:0] s_acc;
        logic signed [33:0] c_acc;
        logic [31:0]        a2;
        logic               sneg;
        logic               neg;
        sfvc_pkg::t_geo     geo;
    } t_term;

    typedef struct packed {
        t_term       b;
        logic [63:0] ps;
        logic [63:0] pc;
        logic [31:0] xs;
        logic [31:0] xc;
    } t_work;

    logic signed [33:0] w_ang;
    logic signed [33:0] w_red;
    logic               w_neg;

    logic               r0_v;
    logic [30:0]        r0_a;
    logic               r0_sneg;
    logic               r0_neg;
    sfvc_pkg::t_geo     r0_geo;
    logic [61:0]        w_sq;

    logic               r_kv [0:sfvc_pkg::TERMS];
    t_term              r_k  [0:sfvc_pkg::TERMS];
    logic               r_av [0:sfvc_pkg::TERMS-1];
    t_work              r_a  [0:sfvc_pkg::TERMS-1];
    logic               r_bv [0:sfvc_pkg::TERMS-1];
    t_work              r_b  [0:sfvc_pkg::TERMS-1];

    logic signed [33:0] w_sfin;
    logic signed [33:0] w_cfin;

    logic               r_fv;
    logic signed [31:0] r_fc;
    logic signed [31:0] r_fs;
    sfvc_pkg::t_geo     r_fgeo;

    // Range reduction into plus or minus pi/2
    always_comb begin
        w_ang = $signed({i_heading[15], i_heading, 17'd0});
        priority if (w_ang > sfvc_pkg::HALF_PI_Q30) begin
            w_red = w_ang - sfvc_pkg::PI_Q30;
            w_neg = 1'b1;
        end else if (w_ang < -sfvc_pkg::HALF_PI_Q30) begin
            w_red = w_ang + sfvc_pkg::PI_Q30;
            w_neg = 1'b1;
        end else begin
            w_red = w_ang;
            w_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (i_en) begin
            r0_v    <= i_valid;
            r0_a    <= 31'(w_red[33] ? -w_red : w_red);
            r0_sneg <= w_red[33];
            r0_neg  <= w_neg;
            r0_geo  <= i_geo;
        end
    end

    // Square of the angle, series seeds
    assign w_sq = 62'(r0_a) * 62'(r0_a);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kv[0] <= 1'b0;
        end else if (i_en) begin
            r_kv[0]       <= r0_v;
            r_k[0].ts     <= {1'b0, r0_a};
            r_k[0].tc     <= sfvc_pkg::ONE_Q30;
            r_k[0].s_acc  <= {3'b000, r0_a};
            r_k[0].c_acc  <= {2'b00, sfvc_pkg::ONE_Q30};
            r_k[0].a2     <= w_sq[61:30];
            r_k[0].sneg   <= r0_sneg;
            r_k[0].neg    <= r0_neg;
            r_k[0].geo    <= r0_geo;
        end
    end

    for (genvar j = 0; j < sfvc_pkg::TERMS; j++) begin : g_term
        logic [31:0] w_qes;
        logic [31:0] w_qec;
        logic [39:0] w_rs;
        logic [39:0] w_rc;
        logic [31:0] w_qs;
        logic [31:0] w_qc;

        // Term times angle squared
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[j] <= 1'b0;
            end else if (i_en) begin
                r_av[j]   <= r_kv[j];
                r_a[j].b  <= r_k[j];
                r_a[j].ps <= 64'(r_k[j].ts) * 64'(r_k[j].a2);
                r_a[j].pc <= 64'(r_k[j].tc) * 64'(r_k[j].a2);
                r_a[j].xs <= '0;
                r_a[j].xc <= '0;
            end
        end

        // Rescale to Q30, multiply by reciprocal of the divisor
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_bv[j] <= 1'b0;
            end else if (i_en) begin
                r_bv[j]   <= r_av[j];
                r_b[j].b  <= r_a[j].b;
                r_b[j].xs <= r_a[j].ps[61:30];
                r_b[j].xc <= r_a[j].pc[61:30];
                r_b[j].ps <= 64'(r_a[j].ps[61:30]) * 64'(sfvc_pkg::SIN_MUL[j]);
                r_b[j].pc <= 64'(r_a[j].pc[61:30]) * 64'(sfvc_pkg::COS_MUL[j]);
            end
        end

        // Quotient estimate plus one correction step
        always_comb begin
            w_qes = 32'(r_b[j].ps >> sfvc_pkg::SIN_SHIFT[j]);
            w_qec = 32'(r_b[j].pc >> sfvc_pkg::COS_SHIFT[j]);
            w_rs  = 40'(r_b[j].xs) - 40'(w_qes) * 40'(sfvc_pkg::SIN_DIV[j]);
            w_rc  = 40'(r_b[j].xc) - 40'(w_qec) * 40'(sfvc_pkg::COS_DIV[j]);
            w_qs  = w_qes + 32'(w_rs >= 40'(sfvc_pkg::SIN_DIV[j]));
            w_qc  = w_qec + 32'(w_rc >= 40'(sfvc_pkg::COS_DIV[j]));
        end

        // Accumulate with alternating sign
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_kv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_kv[j+1]    <= r_bv[j];
                r_k[j+1].a2  <= r_b[j].b.a2;
                r_k[j+1].sneg <= r_b[j].b.sneg;
                r_k[j+1].neg <= r_b[j].b.neg;
                r_k[j+1].geo <= r_b[j].b.geo;
                r_k[j+1].tc  <= w_qc;
                if (j % 2 == 0) begin
                    r_k[j+1].c_acc <= r_b[j].b.c_acc - 34'(w_qc);
                end else begin
                    r_k[j+1].c_acc <= r_b[j].b.c_acc + 34'(w_qc);
                end
                if (j < sfvc_pkg::TERMS - 1) begin
                    r_k[j+1].ts <= w_qs;
                    if (j % 2 == 0) begin
                        r_k[j+1].s_acc <= r_b[j].b.s_acc - 34'(w_qs);
                    end else begin
                        r_k[j+1].s_acc <= r_b[j].b.s_acc + 34'(w_qs);
                    end
                end else begin
                    r_k[j+1].ts    <= r_b[j].b.ts;
                    r_k[j+1].s_acc <= r_b[j].b.s_acc;
                end
            end
        end
    end

    // Quadrant signs
    always_comb begin
        w_sfin = r_k[sfvc_pkg::TERMS].sneg ? -r_k[sfvc_pkg::TERMS].s_acc
                                           :  r_k[sfvc_pkg::TERMS].s_acc;
        w_cfin = r_k[sfvc_pkg::TERMS].c_acc;
        if (r_k[sfvc_pkg::TERMS].neg) begin
            w_sfin = -w_sfin;
            w_cfin = -w_cfin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv   <= r_kv[sfvc_pkg::TERMS];
            r_fc   <= 32'(w_cfin);
            r_fs   <= 32'(w_sfin);
            r_fgeo <= r_k[sfvc_pkg::TERMS].geo;
        end
    end

    assign o_valid = r_fv;
    assign o_cos   = r_fc;
    assign o_sin   = r_fs;
    assign o_geo   = r_fgeo;

endmodule

FILE: sv/sfvc_rot.sv
`timescale 1ns / 1ps

// Rotation, rounding to Q16, offset distance and sum of squares
module sfvc_rot (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic signed [31:0] i_cos,
    input  logic signed [31:0] i_sin,
    input  sfvc_pkg::t_geo     i_geo,
    output logic               o_valid,
    output sfvc_pkg::t_side    o_side,
    output logic [63:0]        o_n
);

    logic [8:1]         r_v;

    logic signed [64:0] r1_p1, r1_p2, r1_p3, r1_p4;
    logic [31:0]        r1_ox, r1_oy;
    sfvc_pkg::t_side    r1_sd;

    logic signed [65:0] r2_x, r2_y;
    logic [31:0]        r2_ox, r2_oy;
    sfvc_pkg::t_side    r2_sd;

    logic [64:0]        r3_mx, r3_my;
    logic               r3_nx, r3_ny;
    logic [31:0]        r3_ox, r3_oy;
    sfvc_pkg::t_side    r3_sd;

    logic [33:0]        r4_mx, r4_my;
    logic               r4_nx, r4_ny;
    logic [31:0]        r4_ox, r4_oy;
    sfvc_pkg::t_side    r4_sd;

    logic [33:0]        r5_ax, r5_ay;
    sfvc_pkg::t_side    r5_sd;

    logic               w_sh;
    logic [31:0]        r6_ax, r6_ay;
    sfvc_pkg::t_side    r6_sd;

    logic [63:0]        r7_qx, r7_qy;
    sfvc_pkg::t_side    r7_sd;

    logic [63:0]        r8_n;
    sfvc_pkg::t_side    r8_sd;

    // Valid bits move with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[7:1], i_valid};
        end
    end

    assign w_sh = (r5_ax[33:31] != 3'd0) || (r5_ay[33:31] != 3'd0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Rotation products, Q46
            r1_p1 <= i_geo.dx * i_cos;
            r1_p2 <= i_geo.dy * i_sin;
            r1_p3 <= i_geo.dx * i_sin;
            r1_p4 <= i_geo.dy * i_cos;
            r1_ox <= i_geo.ox_mag;
            r1_oy <= i_geo.oy_mag;
            r1_sd <= '{c: i_cos, s: i_sin, default: 1'b0};

            // Rotated difference
            r2_x  <= r1_p1 - r1_p2;
            r2_y  <= r1_p3 + r1_p4;
            r2_ox <= r1_ox;
            r2_oy <= r1_oy;
            r2_sd <= r1_sd;

            // Magnitude and sign
            r3_nx <= r2_x[65];
            r3_ny <= r2_y[65];
            r3_mx <= 65'(r2_x[65] ? -r2_x : r2_x);
            r3_my <= 65'(r2_y[65] ? -r2_y : r2_y);
            r3_ox <= r2_ox;
            r3_oy <= r2_oy;
            r3_sd <= r2_sd;

            // Round half away from zero to Q16
            r4_mx <= 34'((r3_mx + 65'd536870912) >> 30);
            r4_my <= 34'((r3_my + 65'd536870912) >> 30);
            r4_nx <= r3_nx;
            r4_ny <= r3_ny;
            r4_ox <= r3_ox;
            r4_oy <= r3_oy;
            r4_sd <= r3_sd;

            // Distance from the offset
            r5_ax <= (r4_mx >= 34'(r4_ox)) ? r4_mx - 34'(r4_ox) : 34'(r4_ox) - r4_mx;
            r5_ay <= (r4_my >= 34'(r4_oy)) ? r4_my - 34'(r4_oy) : 34'(r4_oy) - r4_my;
            r5_sd <= '{c: r4_sd.c, s: r4_sd.s,
                       sx_nz: (r4_mx != 34'd0), sx_neg: r4_nx,
                       sy_nz: (r4_my != 34'd0), sy_neg: r4_ny,
                       sh: 1'b0};

            // Drop to Q14 when either axis is large
            r6_ax <= w_sh ? 32'((r5_ax + 34'd2) >> 2) : r5_ax[31:0];
            r6_ay <= w_sh ? 32'((r5_ay + 34'd2) >> 2) : r5_ay[31:0];
            r6_sd <= '{c: r5_sd.c, s: r5_sd.s,
                       sx_nz: r5_sd.sx_nz, sx_neg: r5_sd.sx_neg,
                       sy_nz: r5_sd.sy_nz, sy_neg: r5_sd.sy_neg,
                       sh: w_sh};

            // Squares
            r7_qx <= 64'(r6_ax) * 64'(r6_ax);
            r7_qy <= 64'(r6_ay) * 64'(r6_ay);
            r7_sd <= r6_sd;

            // Sum of squares
            r8_n  <= r7_qx + r7_qy;
            r8_sd <= r7_sd;
        end
    end

    assign o_valid = r_v[8];
    assign o_side  = r8_sd;
    assign o_n     = r8_n;

endmodule

FILE: sv/sfvc_sqrt.sv
`timescale 1ns / 1ps

// Floor square root of a 64-bit value, two result bits per stage
module sfvc_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [63:0]     i_n,
    input  sfvc_pkg::t_side i_side,
    output logic            o_valid,
    output logic [31:0]     o_root,
    output sfvc_pkg::t_side o_side
);

    localparam int STAGES = 16;

    typedef struct packed {
        logic [33:0]     rem;
        logic [31:0]     root;
        logic [63:0]     n;
        sfvc_pkg::t_side sd;
    } t_sq;

    logic r_v  [0:STAGES-1];
    t_sq  r_q  [0:STAGES-1];
    logic w_vi [0:STAGES-1];
    t_sq  w_qi [0:STAGES-1];

    for (genvar g = 0; g < STAGES; g++) begin : g_stage
        logic [35:0] w_rr;
        logic [35:0] w_trial;
        logic [33:0] w_rem;
        logic [31:0] w_root;

        if (g == 0) begin : g_first
            assign w_vi[g] = i_valid;
            assign w_qi[g] = '{rem: '0, root: '0, n: i_n, sd: i_side};
        end else begin : g_next
            assign w_vi[g] = r_v[g-1];
            assign w_qi[g] = r_q[g-1];
        end

        // Two restoring steps
        always_comb begin
            w_rem  = w_qi[g].rem;
            w_root = w_qi[g].root;
            w_rr   = '0;
            w_trial = '0;
            for (int k = 0; k < 2; k++) begin
                w_rr    = {w_rem, w_qi[g].n[63 - 4*g - 2*k -: 2]};
                w_trial = {2'b00, w_root, 2'b01};
                if (w_rr >= w_trial) begin
                    w_rem  = 34'(w_rr - w_trial);
                    w_root = {w_root[30:0], 1'b1};
                end else begin
                    w_rem  = 34'(w_rr);
                    w_root = {w_root[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g]      <= w_vi[g];
                r_q[g].rem  <= w_rem;
                r_q[g].root <= w_root;
                r_q[g].n    <= w_qi[g].n;
                r_q[g].sd   <= w_qi[g].sd;
            end
        end
    end

    assign o_valid = r_v[STAGES-1];
    assign o_root  = r_q[STAGES-1].root;
    assign o_side  = r_q[STAGES-1].sd;

endmodule

FILE: sv/spring_force_velocity_command_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                 Payload
// input     i_valid / o_ready         i_leader_x/y, i_robot_x/y, i_heading, i_offset_x/y
// result    o_valid / i_ready         o_vel_x/y, o_sat_x/y
// config    i_cfg_valid / o_cfg_ready i_cfg_spring_gain
//
// One request accepted per cycle unless a held result stalls the pipeline.
// Pipeline: 27 stages of Taylor trig (three per term), 8 of rotation and squares,
// 16 of square root, 3 of gain and velocity.
// Reset (synchronous) empties the pipeline and sets the spring gain to 1.0.
// A stalled result freezes every stage; o_ready is high whenever the output is
// empty or being taken, so no request is dropped or repeated.

module spring_force_velocity_command_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_leader_x,
    input  logic signed [31:0] i_leader_y,
    input  logic signed [31:0] i_robot_x,
    input  logic signed [31:0] i_robot_y,
    input  logic signed [15:0] i_heading,
    input  logic signed [31:0] i_offset_x,
    input  logic signed [31:0] i_offset_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_vel_x,
    output logic signed [15:0] o_vel_y,
    output logic               o_sat_x,
    output logic               o_sat_y,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_spring_gain
);

    typedef struct packed {
        logic signed [15:0] vel;
        logic               sat;
    } t_vel;

    logic               w_en;
    logic [15:0]        r_gain;
    sfvc_pkg::t_geo     w_geo;

    logic               w_tv;
    logic signed [31:0] w_cos;
    logic signed [31:0] w_sin;
    sfvc_pkg::t_geo     w_tgeo;

    logic               w_rv;
    sfvc_pkg::t_side    w_rsd;
    logic [63:0]        w_n;

    logic               w_qv;
    logic [31:0]        w_root;
    sfvc_pkg::t_side    w_qsd;

    logic               r_gv;
    logic [49:0]        r_gm;
    sfvc_pkg::t_side    r_gsd;

    logic               r_v1;
    logic [49:0]        r_phx, r_phy;
    logic [63:0]        r_plx, r_ply;
    logic               r_zx, r_zy, r_dx, r_dy;

    logic               r_v2;
    t_vel               r_ox, r_oy;
    t_vel               w_vx, w_vy;

    logic [33:0]        w_mag;
    logic [31:0]        w_cax, w_cay;

    // Rounded velocity magnitude with clamp at full scale
    function automatic t_vel f_vel(input logic [49:0] ph, input logic [63:0] pl,
                                   input logic zero, input logic dir);
        logic [63:0] tot;
        logic [23:0] m;
        logic        sat;
        logic [14:0] mm;
        t_vel        res;
        tot = {10'd0, ph[21:0], 32'd0} + pl + 64'h80_0000_0000;
        m   = tot[63:40];
        sat = (ph[49:22] != 28'd0) || (m >= 24'(sfvc_pkg::VEL_ONE));
        mm  = sat ? sfvc_pkg::VEL_ONE : m[14:0];
        res.vel = dir ? -$signed({1'b0, mm}) : $signed({1'b0, mm});
        res.sat = sat;
        if (zero) begin
            res.vel = '0;
            res.sat = 1'b0;
        end
        return res;
    endfunction

    // Whole pipeline advances unless a result is held
    assign w_en        = !r_v2 || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    // Gain register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= sfvc_pkg::GAIN_RESET;
        end else if (i_cfg_valid) begin
            r_gain <= i_cfg_spring_gain;
        end
    end

    // Position difference and offset magnitudes
    always_comb begin
        w_geo.dx     = 33'(i_leader_x) - 33'(i_robot_x);
        w_geo.dy     = 33'(i_leader_y) - 33'(i_robot_y);
        w_geo.ox_mag = 32'(i_offset_x[31] ? -i_offset_x : i_offset_x);
        w_geo.oy_mag = 32'(i_offset_y[31] ? -i_offset_y : i_offset_y);
    end

    sfvc_trig u_trig (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_valid),
        .i_heading (i_heading),
        .i_geo     (w_geo),
        .o_valid   (w_tv),
        .o_cos     (w_cos),
        .o_sin     (w_sin),
        .o_geo     (w_tgeo)
    );

    sfvc_rot u_rot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_tv),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .i_geo   (w_tgeo),
        .o_valid (w_rv),
        .o_side  (w_rsd),
        .o_n     (w_n)
    );

    sfvc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_rv),
        .i_n     (w_n),
        .i_side  (w_rsd),
        .o_valid (w_qv),
        .o_root  (w_root),
        .o_side  (w_qsd)
    );

    // Magnitude times gain, Q24
    assign w_mag = w_qsd.sh ? {w_root, 2'b00} : {2'b00, w_root};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (w_en) begin
            r_gv  <= w_qv;
            r_gm  <= 50'(w_mag) * 50'(r_gain);
            r_gsd <= w_qsd;
        end
    end

    // Trig magnitude times gained magnitude, split in two partial products
    assign w_cax = 32'(r_gsd.c[31] ? -r_gsd.c : r_gsd.c);
    assign w_cay = 32'(r_gsd.s[31] ? -r_gsd.s : r_gsd.s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1  <= r_gv;
            r_phx <= 50'(w_cax) * 50'(r_gm[49:32]);
            r_phy <= 50'(w_cay) * 50'(r_gm[49:32]);
            r_plx <= 64'(w_cax) * 64'(r_gm[31:0]);
            r_ply <= 64'(w_cay) * 64'(r_gm[31:0]);
            r_zx  <= !r_gsd.sx_nz || (r_gsd.c == 32'sd0);
            r_zy  <= !r_gsd.sy_nz || (r_gsd.s == 32'sd0);
            r_dx  <= r_gsd.sx_neg ^ r_gsd.c[31];
            r_dy  <= r_gsd.sy_neg ^ r_gsd.s[31];
        end
    end

    // Output register
    assign w_vx = f_vel(r_phx, r_plx, r_zx, r_dx);
    assign w_vy = f_vel(r_phy, r_ply, r_zy, r_dy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
            r_ox <= w_vx;
            r_oy <= w_vy;
        end
    end

    assign o_valid = r_v2;
    assign o_vel_x = r_ox.vel;
    assign o_vel_y = r_oy.vel;
    assign o_sat_x = r_ox.sat;
    assign o_sat_y = r_oy.sat;

    // A clamped velocity sits exactly at full scale
    a_sat_x_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sat_x) |-> (o_vel_x == 16'sd16384 || o_vel_x == -16'sd16384))
        else $error("x saturation flag without full-scale velocity");

    a_sat_y_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_sat_y) |-> (o_vel_y == 16'sd16384 || o_vel_y == -16'sd16384))
        else $error("y saturation flag without full-scale velocity");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A held result stalls the input side
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("request taken while result is held");

endmodule
